### src/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
`default_nettype none
package hsv2rgb_pkg;

    // Degrees in one turn and in one hue sector
    localparam int DEG_TURN   = 360;
    localparam int SECTOR_DEG = 60;

    // 92 turns: moves any 16-bit signed hue onto a positive 17-bit value
    localparam logic [16:0] HUE_OFFSET = 17'd33120;

    // x / 360 for x < 2^17: (x * RECIP_360) >> 25, high by at most one
    localparam logic [16:0] RECIP_360       = 17'd93207;
    localparam int          RECIP_360_SHIFT = 25;
    localparam int          TURN_Q_W        = 8;

    // d / 60 for d <= 15300: (d * RECIP_60) >> 16, high by at most one
    localparam logic [10:0] RECIP_60       = 11'd1093;
    localparam int          RECIP_60_SHIFT = 16;
    localparam int          SCALED_W       = 14;

    typedef logic [7:0] t_chan;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

endpackage
`default_nettype wire

### src/hsv_to_rgb_pixel.sv
// HSV to 8-bit RGB pixel converter, top level.
// Throughput: one pixel per cycle while the output is not stalled; each of the
// ten stages has its own valid bit and fills bubbles while the output is stalled.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module hsv_to_rgb_pixel #(
    parameter int FRACTION_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_hue_degrees,
    input  wire logic [15:0] i_saturation,
    input  wire logic [15:0] i_brightness,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue
);
    logic                         w_hue_valid, w_hue_ready;
    hsv2rgb_pkg::t_sector         w_hue_sector;
    logic [5:0]                   w_hue_rem;
    logic [FRACTION_BITS:0]       w_hue_sat, w_hue_val;

    logic                         w_trm_valid, w_trm_ready;
    hsv2rgb_pkg::t_sector         w_trm_sector;
    logic [hsv2rgb_pkg::SCALED_W-1:0] w_trm_q, w_trm_t;
    hsv2rgb_pkg::t_chan           w_trm_p, w_trm_v;

    hsv2rgb_hue #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_hue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_hue    (i_hue_degrees),
        .i_sat    (i_saturation),
        .i_val    (i_brightness),
        .o_valid  (w_hue_valid),
        .i_ready  (w_hue_ready),
        .o_sector (w_hue_sector),
        .o_rem    (w_hue_rem),
        .o_sat    (w_hue_sat),
        .o_val    (w_hue_val)
    );

    hsv2rgb_terms #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_terms (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_hue_valid),
        .o_ready    (w_hue_ready),
        .i_sector   (w_hue_sector),
        .i_rem      (w_hue_rem),
        .i_sat      (w_hue_sat),
        .i_val      (w_hue_val),
        .o_valid    (w_trm_valid),
        .i_ready    (w_trm_ready),
        .o_sector   (w_trm_sector),
        .o_scaled_q (w_trm_q),
        .o_scaled_t (w_trm_t),
        .o_chan_p   (w_trm_p),
        .o_chan_v   (w_trm_v)
    );

    hsv2rgb_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_trm_valid),
        .o_ready    (w_trm_ready),
        .i_sector   (w_trm_sector),
        .i_scaled_q (w_trm_q),
        .i_scaled_t (w_trm_t),
        .i_chan_p   (w_trm_p),
        .i_chan_v   (w_trm_v),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue)
    );

endmodule
`default_nettype wire

### src/hsv2rgb_hue.sv
// Hue wrap and sector split, input clamping: four pipeline stages.
`default_nettype none
module hsv2rgb_hue #(
    parameter int FRACTION_BITS = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [15:0]               i_hue,
    input  wire logic [15:0]               i_sat,
    input  wire logic [15:0]               i_val,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output hsv2rgb_pkg::t_sector           o_sector,
    output logic [5:0]                     o_rem,
    output logic [FRACTION_BITS:0]         o_sat,
    output logic [FRACTION_BITS:0]         o_val
);
    localparam int UW = FRACTION_BITS + 1;
    localparam logic [17:0] ONE = 18'd1 << FRACTION_BITS;

    function automatic logic [UW-1:0] clamp_unit(input logic [15:0] raw);
        logic signed [17:0] x;
        x = 18'(signed'(raw));
        if (x < 18'sd0) begin
            return '0;
        end else if (x > signed'(ONE)) begin
            return UW'(ONE);
        end else begin
            return UW'(x);
        end
    endfunction

    logic [3:0] r_vld;
    logic [3:0] w_en;

    logic [16:0]   r_s1_x;
    logic [UW-1:0] r_s1_sat, r_s1_val;

    logic [hsv2rgb_pkg::TURN_Q_W-1:0] r_s2_q;
    logic [16:0]   r_s2_x;
    logic [UW-1:0] r_s2_sat, r_s2_val;

    logic [8:0]    r_s3_h;
    logic [UW-1:0] r_s3_sat, r_s3_val;

    hsv2rgb_pkg::t_sector r_s4_sec;
    logic [5:0]    r_s4_rem;
    logic [UW-1:0] r_s4_sat, r_s4_val;

    logic [33:0]        w_prod;
    logic signed [17:0] w_diff;
    logic [8:0]         w_h;
    hsv2rgb_pkg::t_sector w_sec;
    logic [8:0]         w_base;

    always_comb begin
        w_en[3] = !r_vld[3] || i_ready;
        w_en[2] = !r_vld[2] || w_en[3];
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_comb begin
        w_prod = 34'(r_s1_x) * 34'(hsv2rgb_pkg::RECIP_360);
        w_diff = signed'({1'b0, r_s2_x})
               - signed'(18'(r_s2_q) * 18'(hsv2rgb_pkg::DEG_TURN));
        if (w_diff < 18'sd0) begin
            w_h = 9'(w_diff + 18'(hsv2rgb_pkg::DEG_TURN));
        end else begin
            w_h = 9'(w_diff);
        end
        if (r_s3_h >= 9'd300) begin
            w_sec  = hsv2rgb_pkg::SEC_MAG_RED;
            w_base = 9'd300;
        end else if (r_s3_h >= 9'd240) begin
            w_sec  = hsv2rgb_pkg::SEC_BLU_MAG;
            w_base = 9'd240;
        end else if (r_s3_h >= 9'd180) begin
            w_sec  = hsv2rgb_pkg::SEC_CYN_BLU;
            w_base = 9'd180;
        end else if (r_s3_h >= 9'd120) begin
            w_sec  = hsv2rgb_pkg::SEC_GRN_CYN;
            w_base = 9'd120;
        end else if (r_s3_h >= 9'd60) begin
            w_sec  = hsv2rgb_pkg::SEC_YEL_GRN;
            w_base = 9'd60;
        end else begin
            w_sec  = hsv2rgb_pkg::SEC_RED_YEL;
            w_base = 9'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_x   <= 17'(signed'(i_hue)) + hsv2rgb_pkg::HUE_OFFSET;
            r_s1_sat <= clamp_unit(i_sat);
            r_s1_val <= clamp_unit(i_val);
        end
        if (w_en[1]) begin
            r_s2_q   <= w_prod[hsv2rgb_pkg::RECIP_360_SHIFT +: hsv2rgb_pkg::TURN_Q_W];
            r_s2_x   <= r_s1_x;
            r_s2_sat <= r_s1_sat;
            r_s2_val <= r_s1_val;
        end
        if (w_en[2]) begin
            r_s3_h   <= w_h;
            r_s3_sat <= r_s2_sat;
            r_s3_val <= r_s2_val;
        end
        if (w_en[3]) begin
            r_s4_sec <= w_sec;
            r_s4_rem <= 6'(r_s3_h - w_base);
            r_s4_sat <= r_s3_sat;
            r_s4_val <= r_s3_val;
        end
    end

    assign o_valid  = r_vld[3];
    assign o_sector = r_s4_sec;
    assign o_rem    = r_s4_rem;
    assign o_sat    = r_s4_sat;
    assign o_val    = r_s4_val;

endmodule
`default_nettype wire

### src/hsv2rgb_terms.sv
// p, q and t term products and v, scaled by 255: four pipeline stages.
`default_nettype none
module hsv2rgb_terms #(
    parameter int FRACTION_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire hsv2rgb_pkg::t_sector          i_sector,
    input  wire logic [5:0]                    i_rem,
    input  wire logic [FRACTION_BITS:0]        i_sat,
    input  wire logic [FRACTION_BITS:0]        i_val,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output hsv2rgb_pkg::t_sector               o_sector,
    output logic [hsv2rgb_pkg::SCALED_W-1:0]   o_scaled_q,
    output logic [hsv2rgb_pkg::SCALED_W-1:0]   o_scaled_t,
    output hsv2rgb_pkg::t_chan                 o_chan_p,
    output hsv2rgb_pkg::t_chan                 o_chan_v
);
    localparam int UW = FRACTION_BITS + 1;
    localparam int AW = FRACTION_BITS + 6;
    localparam int BW = UW + AW;
    localparam int PW = 2 * UW;
    localparam int SH = 2 * FRACTION_BITS;
    localparam logic [UW-1:0] ONE       = UW'(1) << FRACTION_BITS;
    localparam logic [AW-1:0] SIXTY_ONE = AW'(hsv2rgb_pkg::SECTOR_DEG) << FRACTION_BITS;

    logic [3:0] r_vld;
    logic [3:0] w_en;

    hsv2rgb_pkg::t_sector r_t1_sec, r_t2_sec, r_t3_sec, r_t4_sec;
    logic [AW-1:0] r_t1_sr_q, r_t1_sr_t;
    logic [UW-1:0] r_t1_oms, r_t1_val;
    logic [AW-1:0] r_t2_a_q, r_t2_a_t;
    logic [UW-1:0] r_t2_oms, r_t2_val;
    logic [BW-1:0] r_t3_b_q, r_t3_b_t;
    logic [PW-1:0] r_t3_b_p;
    logic [UW-1:0] r_t3_val;
    logic [hsv2rgb_pkg::SCALED_W-1:0] r_t4_q, r_t4_t;
    hsv2rgb_pkg::t_chan r_t4_p, r_t4_v;

    logic [5:0]      w_rem_c;
    logic [BW+7:0]   w_c_q, w_c_t;
    logic [PW+7:0]   w_c_p;
    logic [UW+7:0]   w_c_v;

    always_comb begin
        w_en[3] = !r_vld[3] || i_ready;
        w_en[2] = !r_vld[2] || w_en[3];
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // 255*x as (x << 8) - x
    always_comb begin
        w_rem_c = 6'(hsv2rgb_pkg::SECTOR_DEG) - i_rem;
        w_c_q   = {r_t3_b_q, 8'd0} - (BW+8)'(r_t3_b_q);
        w_c_t   = {r_t3_b_t, 8'd0} - (BW+8)'(r_t3_b_t);
        w_c_p   = {r_t3_b_p, 8'd0} - (PW+8)'(r_t3_b_p);
        w_c_v   = {r_t3_val, 8'd0} - (UW+8)'(r_t3_val);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_t1_sec  <= i_sector;
            r_t1_sr_q <= AW'(i_sat) * AW'(i_rem);
            r_t1_sr_t <= AW'(i_sat) * AW'(w_rem_c);
            r_t1_oms  <= ONE - i_sat;
            r_t1_val  <= i_val;
        end
        if (w_en[1]) begin
            r_t2_sec <= r_t1_sec;
            r_t2_a_q <= SIXTY_ONE - r_t1_sr_q;
            r_t2_a_t <= SIXTY_ONE - r_t1_sr_t;
            r_t2_oms <= r_t1_oms;
            r_t2_val <= r_t1_val;
        end
        if (w_en[2]) begin
            r_t3_sec <= r_t2_sec;
            r_t3_b_q <= BW'(r_t2_val) * BW'(r_t2_a_q);
            r_t3_b_t <= BW'(r_t2_val) * BW'(r_t2_a_t);
            r_t3_b_p <= PW'(r_t2_val) * PW'(r_t2_oms);
            r_t3_val <= r_t2_val;
        end
        if (w_en[3]) begin
            r_t4_sec <= r_t3_sec;
            r_t4_q   <= w_c_q[SH +: hsv2rgb_pkg::SCALED_W];
            r_t4_t   <= w_c_t[SH +: hsv2rgb_pkg::SCALED_W];
            r_t4_p   <= w_c_p[SH +: 8];
            r_t4_v   <= w_c_v[FRACTION_BITS +: 8];
        end
    end

    assign o_valid    = r_vld[3];
    assign o_sector   = r_t4_sec;
    assign o_scaled_q = r_t4_q;
    assign o_scaled_t = r_t4_t;
    assign o_chan_p   = r_t4_p;
    assign o_chan_v   = r_t4_v;

endmodule
`default_nettype wire

### src/hsv2rgb_out.sv
// Divide q and t terms by 60 and route channels by sector: two stages.
`default_nettype none
module hsv2rgb_out (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire hsv2rgb_pkg::t_sector          i_sector,
    input  wire logic [hsv2rgb_pkg::SCALED_W-1:0] i_scaled_q,
    input  wire logic [hsv2rgb_pkg::SCALED_W-1:0] i_scaled_t,
    input  wire hsv2rgb_pkg::t_chan            i_chan_p,
    input  wire hsv2rgb_pkg::t_chan            i_chan_v,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output hsv2rgb_pkg::t_chan                 o_red,
    output hsv2rgb_pkg::t_chan                 o_green,
    output hsv2rgb_pkg::t_chan                 o_blue
);
    localparam int DW = hsv2rgb_pkg::SCALED_W;
    localparam int MW = DW + 11;

    logic [1:0] r_vld;
    logic [1:0] w_en;

    hsv2rgb_pkg::t_sector r_o1_sec;
    logic [MW-1:0] r_o1_m_q, r_o1_m_t;
    logic [DW-1:0] r_o1_d_q, r_o1_d_t;
    hsv2rgb_pkg::t_chan r_o1_p, r_o1_v;
    hsv2rgb_pkg::t_chan r_red, r_green, r_blue;

    logic [8:0] w_est_q, w_est_t;
    hsv2rgb_pkg::t_chan w_cq, w_ct;

    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
        end
    end

    // reciprocal estimate may be one high
    always_comb begin
        w_est_q = r_o1_m_q[hsv2rgb_pkg::RECIP_60_SHIFT +: 9];
        w_est_t = r_o1_m_t[hsv2rgb_pkg::RECIP_60_SHIFT +: 9];
        if ((DW+1)'(w_est_q) * (DW+1)'(hsv2rgb_pkg::SECTOR_DEG) > (DW+1)'(r_o1_d_q)) begin
            w_cq = 8'(w_est_q - 9'd1);
        end else begin
            w_cq = 8'(w_est_q);
        end
        if ((DW+1)'(w_est_t) * (DW+1)'(hsv2rgb_pkg::SECTOR_DEG) > (DW+1)'(r_o1_d_t)) begin
            w_ct = 8'(w_est_t - 9'd1);
        end else begin
            w_ct = 8'(w_est_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_o1_sec <= i_sector;
            r_o1_m_q <= MW'(i_scaled_q) * MW'(hsv2rgb_pkg::RECIP_60);
            r_o1_m_t <= MW'(i_scaled_t) * MW'(hsv2rgb_pkg::RECIP_60);
            r_o1_d_q <= i_scaled_q;
            r_o1_d_t <= i_scaled_t;
            r_o1_p   <= i_chan_p;
            r_o1_v   <= i_chan_v;
        end
        if (w_en[1]) begin
            case (r_o1_sec)
                hsv2rgb_pkg::SEC_YEL_GRN: begin
                    r_red <= w_cq;   r_green <= r_o1_v; r_blue <= r_o1_p;
                end
                hsv2rgb_pkg::SEC_GRN_CYN: begin
                    r_red <= r_o1_p; r_green <= r_o1_v; r_blue <= w_ct;
                end
                hsv2rgb_pkg::SEC_CYN_BLU: begin
                    r_red <= r_o1_p; r_green <= w_cq;   r_blue <= r_o1_v;
                end
                hsv2rgb_pkg::SEC_BLU_MAG: begin
                    r_red <= w_ct;   r_green <= r_o1_p; r_blue <= r_o1_v;
                end
                hsv2rgb_pkg::SEC_MAG_RED: begin
                    r_red <= r_o1_v; r_green <= r_o1_p; r_blue <= w_cq;
                end
                default: begin
                    r_red <= r_o1_v; r_green <= w_ct;   r_blue <= r_o1_p;
                end
            endcase
        end
    end

    assign o_valid = r_vld[1];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule
`default_nettype wire
